// File: design/rdfd_pkg.sv
// Shared types and constants for the run-length / delta frame decoder.
// No dependencies; used by rdfd_ctrl, rdfd_dp and the top level.
`default_nettype none
package rdfd_pkg;

  localparam int CODE_W    = 8;
  localparam int FRAME_W   = 16;
  localparam int ADDR_W    = 16;
  localparam int MODE_W    = 2;
  localparam int PEND_W    = 4;
  localparam int RUN_CNT_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  localparam logic [CODE_W-1:0]    RUN_CODE_MAX   = 8'h0F;
  localparam logic [CODE_W-1:0]    DELTA_CODE_MAX = 8'h0E;
  localparam logic [CODE_W-1:0]    SKIP_VALUE     = 8'h0F;
  // first item of a run is issued on decode, so the counter holds the rest
  localparam logic [RUN_CNT_W-1:0] RUN_REST_BIAS  = 5'd2;

  localparam logic [MODE_W-1:0]  MODE_COPY  = 2'd0;
  localparam logic [MODE_W-1:0]  MODE_RLE   = 2'd1;
  localparam logic [MODE_W-1:0]  MODE_DELTA = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DECODE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_PIXELS = 2'd1;

  localparam logic [FRAME_W-1:0] FRAME_PIXELS_RST = 16'd64000;

  typedef struct packed {
    logic emit;        // load the output register
    logic emit_write;  // write flag before the overflow check
    logic emit_last;   // last result of this item
    logic load_run;    // load remaining count from the pending code
    logic run_step;    // count one run result
    logic set_pending; // store a run code
    logic clear_wait;  // drop the waiting run
    logic consume;     // item finished: free the holding register
  } ctrl_cmd_t;

  typedef struct packed {
    logic hold_valid;
    logic mode_copy;
    logic run_waiting;
    logic is_code;
    logic skip;
    logic cnt_one;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// File: design/rdfd_ctrl.sv
// Controller of the frame decoder: decides per held item what the datapath does.
// Depends on rdfd_pkg.
`default_nettype none
module rdfd_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire rdfd_pkg::dp_status_t st,
  output rdfd_pkg::ctrl_cmd_t  cmd
);

  localparam logic S_DECODE = 1'b0;
  localparam logic S_RUN    = 1'b1;

  logic state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_DECODE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_DECODE: begin
        if (st.hold_valid) begin
          if (st.mode_copy) begin
            if (st.out_free) begin
              cmd.emit       = 1'b1;
              cmd.emit_write = 1'b1;
              cmd.emit_last  = 1'b1;
              cmd.clear_wait = 1'b1;
              cmd.consume    = 1'b1;
            end
          end else if (st.run_waiting) begin
            // first result of the run; the rest come from S_RUN
            if (st.out_free) begin
              cmd.emit       = 1'b1;
              cmd.emit_write = !st.skip;
              cmd.load_run   = 1'b1;
              cmd.clear_wait = 1'b1;
              state_nxt      = S_RUN;
            end
          end else if (st.is_code) begin
            cmd.set_pending = 1'b1;
            cmd.consume     = 1'b1;
          end else if (st.out_free) begin
            cmd.emit       = 1'b1;
            cmd.emit_write = !st.skip;
            cmd.emit_last  = 1'b1;
            cmd.consume    = 1'b1;
          end
        end
      end
      S_RUN: begin
        if (st.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_write = !st.skip;
          cmd.emit_last  = st.cnt_one;
          cmd.run_step   = 1'b1;
          if (st.cnt_one) begin
            cmd.consume = 1'b1;
            state_nxt   = S_DECODE;
          end
        end
      end
      default: state_nxt = S_DECODE;
    endcase
  end

endmodule
`default_nettype wire

// File: design/rdfd_dp.sv
// Datapath of the frame decoder: holding register, config registers, run state,
// write position and the output register. Depends on rdfd_pkg.
`default_nettype none
module rdfd_dp #(
  parameter int ADDRESS_BITS = 16
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  [rdfd_pkg::CODE_W-1:0]           in_code_byte,
  input  wire                                   in_frame_last,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [rdfd_pkg::ADDR_W-1:0]           out_pixel_address,
  output logic [rdfd_pkg::CODE_W-1:0]           out_pixel_value,
  output logic                                  out_write_pixel,
  output logic                                  out_run_last,
  output logic                                  out_overflow,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire  [rdfd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire  [rdfd_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  wire rdfd_pkg::ctrl_cmd_t              cmd,
  output rdfd_pkg::dp_status_t                  st
);

  localparam int POS_W = ADDRESS_BITS + 1;  // top bit marks saturation

  logic                               hold_valid_r;
  logic [rdfd_pkg::CODE_W-1:0]        hold_byte_r;
  logic                               hold_last_r;
  logic [rdfd_pkg::MODE_W-1:0]        mode_r;
  logic [rdfd_pkg::FRAME_W-1:0]       frame_pixels_r;
  logic [rdfd_pkg::PEND_W-1:0]        pending_r, pending_nxt;
  logic                               waiting_r, waiting_nxt;
  logic [POS_W-1:0]                   pos_r, pos_nxt;
  logic [rdfd_pkg::RUN_CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                               out_valid_r;
  logic [rdfd_pkg::ADDR_W-1:0]        addr_r;
  logic [rdfd_pkg::CODE_W-1:0]        value_r;
  logic                               write_r, last_r, over_r;

  logic delta, over_now, out_free, in_take, cfg_take;

  assign delta     = mode_r[1];
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = hold_valid_r && !cmd.consume;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign over_now  = (32'(pos_r) >= 32'(frame_pixels_r)) || pos_r[ADDRESS_BITS];

  always_comb begin
    st.hold_valid  = hold_valid_r;
    st.mode_copy   = (mode_r == rdfd_pkg::MODE_COPY);
    st.run_waiting = waiting_r;
    st.is_code     = delta ? (hold_byte_r <= rdfd_pkg::DELTA_CODE_MAX)
                           : (hold_byte_r <= rdfd_pkg::RUN_CODE_MAX);
    st.skip        = delta && (hold_byte_r == rdfd_pkg::SKIP_VALUE);
    st.cnt_one     = (cnt_r == rdfd_pkg::RUN_CNT_W'(1));
    st.out_free    = out_free;
  end

  // run state and write position
  always_comb begin
    pending_nxt = pending_r;
    waiting_nxt = waiting_r;
    pos_nxt     = pos_r;
    cnt_nxt     = cnt_r;
    if (cmd.clear_wait) waiting_nxt = 1'b0;
    if (cmd.set_pending) begin
      pending_nxt = hold_byte_r[rdfd_pkg::PEND_W-1:0];
      waiting_nxt = 1'b1;
    end
    if (cmd.load_run)
      cnt_nxt = rdfd_pkg::RUN_CNT_W'(pending_r) + rdfd_pkg::RUN_REST_BIAS;
    else if (cmd.run_step)
      cnt_nxt = cnt_r - rdfd_pkg::RUN_CNT_W'(1);
    if (cmd.emit && !pos_r[ADDRESS_BITS]) pos_nxt = pos_r + POS_W'(1);
    if (cmd.consume && hold_last_r) begin
      // frame end: drop any unpaired code and restart at position zero
      waiting_nxt = 1'b0;
      pending_nxt = '0;
      pos_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r   <= 1'b0;
      mode_r         <= rdfd_pkg::MODE_RLE;
      frame_pixels_r <= rdfd_pkg::FRAME_PIXELS_RST;
      pending_r      <= '0;
      waiting_r      <= 1'b0;
      pos_r          <= '0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      waiting_r <= waiting_nxt;
      pos_r     <= pos_nxt;
      cnt_r     <= cnt_nxt;
      if (in_take) begin
        hold_valid_r <= 1'b1;
      end else if (cmd.consume) begin
        hold_valid_r <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_take) begin
        unique case (cfg_index)
          rdfd_pkg::REG_DECODE_MODE:  mode_r <= cfg_data[rdfd_pkg::MODE_W-1:0];
          rdfd_pkg::REG_FRAME_PIXELS: frame_pixels_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_byte_r <= in_code_byte;
      hold_last_r <= in_frame_last;
    end
    if (cmd.emit) begin
      addr_r  <= rdfd_pkg::ADDR_W'(pos_r);
      value_r <= hold_byte_r;
      write_r <= cmd.emit_write && !over_now;
      last_r  <= cmd.emit_last;
      over_r  <= over_now;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pixel_address = addr_r;
  assign out_pixel_value   = value_r;
  assign out_write_pixel   = write_r;
  assign out_run_last      = last_r;
  assign out_overflow      = over_r;

endmodule
`default_nettype wire

// File: design/rle_delta_frame_decoder_top.sv
// Top level of the run-length / delta-skip frame decoder.
// Depends on rdfd_pkg, rdfd_ctrl and rdfd_dp.
//
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+---------------
//  input   | in_code_byte, in_frame_last                      | in_valid/in_stall
//  result  | out_pixel_address/value, out_write_pixel,        | out_valid/out_stall
//          | out_run_last, out_overflow                       |
//  config  | cfg_index, cfg_data                              | cfg_valid/cfg_ready
//
// Each item is registered in a holding register, where the controller works on it.
// A literal or copied byte gives one result, a run code none, and the byte after
// a run code gives code+3 results (one result a cycle while out_stall is low).
// Result stalls hold the controller; a held item not consumed stalls the input.
// Reset is synchronous, active low; there is no start-up sweep.
`default_nettype none
module rle_delta_frame_decoder_top #(
  parameter int ADDRESS_BITS = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [rdfd_pkg::CODE_W-1:0]        in_code_byte,
  input  wire                                in_frame_last,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [rdfd_pkg::ADDR_W-1:0]        out_pixel_address,
  output logic [rdfd_pkg::CODE_W-1:0]        out_pixel_value,
  output logic                               out_write_pixel,
  output logic                               out_run_last,
  output logic                               out_overflow,
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [rdfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [rdfd_pkg::CFG_DAT_W-1:0]     cfg_data
);

  rdfd_pkg::ctrl_cmd_t  cmd;
  rdfd_pkg::dp_status_t st;

  rdfd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cmd   (cmd)
  );

  rdfd_dp #(
    .ADDRESS_BITS (ADDRESS_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_code_byte      (in_code_byte),
    .in_frame_last     (in_frame_last),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_pixel_address (out_pixel_address),
    .out_pixel_value   (out_pixel_value),
    .out_write_pixel   (out_write_pixel),
    .out_run_last      (out_run_last),
    .out_overflow      (out_overflow),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .st                (st)
  );

endmodule
`default_nettype wire
